// File: src/round_robin_task_scheduler_sem_core_macros.svh
// Assertion macros for the scheduler core.
// Depends on nothing; the top level takes this header by include.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_SEM_CORE_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_SEM_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define RRTS_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("rrts assertion failed");
`define RRTS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  `RRTS_ASSERT(lbl, ck, rs, (ante) |-> (cons))
`else
`define RRTS_ASSERT(lbl, ck, rs, prop)
`define RRTS_ASSERT_IMP(lbl, ck, rs, ante, cons)
`endif

`endif

// File: src/rrts_pkg.sv
// Shared types and constants of the round-robin scheduler core.
// No dependencies; used by the task RAM, the semaphore file and the top level.
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int SEM_SLOTS  = 4;

  localparam int TID_W  = $clog2(TASK_SLOTS);
  localparam int BLK_W  = $clog2(SEM_SLOTS + 1);
  localparam int SIDX_W = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
  localparam int CNT_W  = 9;

  typedef logic [TID_W-1:0]        tid_t;
  typedef logic signed [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_MAX = 9'sd255;
  localparam cnt_t CNT_MIN = 9'sh100;

  typedef enum logic [2:0] {
    ACT_CREATE = 3'd0,
    ACT_SCHED  = 3'd1,
    ACT_INIT   = 3'd2,
    ACT_WAIT   = 3'd3,
    ACT_SIGNAL = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    PH_FREE    = 2'd0,
    PH_CREATED = 2'd1,
    PH_READY   = 2'd2,
    PH_RUNNING = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_SLOT   = 2'd1,
    STS_NO_RUN    = 2'd2,
    STS_NO_WAITER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDCUR,
    S_CREATE2,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    tid_t             nxt;
    phase_t           ph;
    logic [BLK_W-1:0] blk;
  } task_ent_t;

  typedef struct packed {
    logic      en;
    tid_t      addr;
    task_ent_t data;
  } ram_wr_t;

endpackage

// File: src/rrts_task_ram.sv
// Task table RAM: ring link, phase and blocking semaphore per slot.
// Depends on rrts_pkg. One write and one read port, read data registered.
`timescale 1ns / 1ps

module rrts_task_ram (
  input  logic               clk,
  input  logic               rst,
  input  rrts_pkg::ram_wr_t  wr,
  input  rrts_pkg::tid_t     rd_addr,
  output rrts_pkg::task_ent_t rd_data
);

  rrts_pkg::task_ent_t mem [rrts_pkg::TASK_SLOTS];
  logic [rrts_pkg::TASK_SLOTS-1:0] valid;
  rrts_pkg::task_ent_t rd_q;
  logic                rd_vld;
  rrts_pkg::tid_t      rd_idx;
  rrts_pkg::task_ent_t rst_ent;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q   <= mem[rd_addr];
    rd_idx <= rd_addr;
  end

  // Valid bits stand in for clearing the table: an unwritten slot reads as reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= valid[rd_addr];
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    rst_ent.nxt = '0;
    rst_ent.ph  = (rd_idx == '0) ? rrts_pkg::PH_CREATED : rrts_pkg::PH_FREE;
    rst_ent.blk = '0;
    rd_data     = rd_vld ? rd_q : rst_ent;
  end

endmodule

// File: src/rrts_sem_file.sv
// Semaphore count registers with saturating wait and signal updates.
// Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_sem_file (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  rrts_pkg::act_t            action,
  input  logic [rrts_pkg::SIDX_W-1:0] idx,
  input  logic [7:0]                init_count,
  output rrts_pkg::cnt_t            cnt_new
);

  rrts_pkg::cnt_t cnt [rrts_pkg::SEM_SLOTS];
  rrts_pkg::cnt_t cur;

  always_comb begin
    cur = cnt[idx];
    case (action)
      rrts_pkg::ACT_INIT:   cnt_new = $signed({1'b0, init_count});
      rrts_pkg::ACT_WAIT:   cnt_new = (cur > rrts_pkg::CNT_MIN) ? cur - 9'sd1 : cur;
      rrts_pkg::ACT_SIGNAL: cnt_new = (cur < rrts_pkg::CNT_MAX) ? cur + 9'sd1 : cur;
      default:              cnt_new = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rrts_pkg::SEM_SLOTS; i++) begin
        cnt[i] <= '0;
      end
    end else if (en) begin
      cnt[idx] <= cnt_new;
    end
  end

endmodule

// File: src/round_robin_task_scheduler_sem_core.sv
// Accept to result valid: init, wait without blocking, signal without wakeup, unused
// actions and create on a full ring go straight to the result; a blocking wait reads
// and marks the current task; create adds the new slot, then relinks; schedule and a
// signal that must wake a waiter walk k = 1..8 ring entries, one per cycle from the task
// RAM. One item at a time; the next item is taken once the result is registered.
// Synchronous reset: idle task current, slot 0 linked to itself, counts zero.
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_sem_core_macros.svh"

module round_robin_task_scheduler_sem_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [1:0] sem_id, [9:2] init_count, [15:10] zero
  input  logic [2:0]  s_tuser,  // [2:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // [2:0] task_id, [3] first_run, [4] suspend_request,
                                // [6:5] status, [15:7] sem_value
);

  rrts_pkg::state_t    state, state_next;
  rrts_pkg::tid_t      cur_tid;
  logic [rrts_pkg::TID_W:0] next_free_id;
  rrts_pkg::act_t      act;
  logic [1:0]          sem;
  rrts_pkg::tid_t      walk_t;
  rrts_pkg::tid_t      cnt;
  rrts_pkg::task_ent_t ent;
  rrts_pkg::tid_t      res_tid;
  logic                res_first;
  logic                res_susp;
  rrts_pkg::status_t   res_status;
  rrts_pkg::cnt_t      res_semv;

  logic                accept;
  rrts_pkg::act_t      act_in;
  logic [1:0]          sem_in;
  logic                sem_ok;
  logic                sem_op;
  logic                ring_full;
  rrts_pkg::cnt_t      cnt_new;
  rrts_pkg::ram_wr_t   wr;
  rrts_pkg::tid_t      rd_addr;
  rrts_pkg::task_ent_t rd;
  logic                match;
  logic                last_step;
  logic                out_load;
  logic [rrts_pkg::BLK_W-1:0] sem_code;

  assign s_tready  = (state == rrts_pkg::S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign act_in    = rrts_pkg::act_t'(s_tuser);
  assign sem_in    = s_tdata[1:0];
  assign sem_ok    = (32'(sem_in) < rrts_pkg::SEM_SLOTS);
  assign sem_op    = sem_ok && (act_in == rrts_pkg::ACT_INIT || act_in == rrts_pkg::ACT_WAIT ||
                                act_in == rrts_pkg::ACT_SIGNAL);
  assign ring_full = (next_free_id >= (rrts_pkg::TID_W + 1)'(rrts_pkg::TASK_SLOTS));
  assign sem_code  = rrts_pkg::BLK_W'(sem) + rrts_pkg::BLK_W'(1);
  assign last_step = (cnt == rrts_pkg::tid_t'(rrts_pkg::TASK_SLOTS - 1));
  assign out_load  = (state == rrts_pkg::S_DONE) && (!m_tvalid || m_tready);

  rrts_sem_file u_sem (
    .clk        (clk),
    .rst        (rst),
    .en         (accept && sem_op),
    .action     (act_in),
    .idx        (sem_in[rrts_pkg::SIDX_W-1:0]),
    .init_count (s_tdata[9:2]),
    .cnt_new    (cnt_new)
  );

  rrts_task_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and RAM port control.
  always_comb begin
    state_next = state;
    rd_addr    = cur_tid;
    wr         = '0;
    match      = (act == rrts_pkg::ACT_SCHED) ? (rd.blk == '0) : (rd.blk == sem_code);
    case (state)
      rrts_pkg::S_IDLE: begin
        if (accept) begin
          case (act_in)
            rrts_pkg::ACT_CREATE: state_next = ring_full ? rrts_pkg::S_DONE : rrts_pkg::S_RDCUR;
            rrts_pkg::ACT_SCHED:  state_next = rrts_pkg::S_RDCUR;
            rrts_pkg::ACT_WAIT:
              state_next = (sem_ok && cnt_new < 0) ? rrts_pkg::S_RDCUR : rrts_pkg::S_DONE;
            rrts_pkg::ACT_SIGNAL:
              state_next = (sem_ok && cnt_new <= 0) ? rrts_pkg::S_RDCUR : rrts_pkg::S_DONE;
            default: state_next = rrts_pkg::S_DONE;
          endcase
        end
      end
      rrts_pkg::S_RDCUR: begin
        case (act)
          rrts_pkg::ACT_CREATE: begin
            wr.en       = 1'b1;
            wr.addr     = next_free_id[rrts_pkg::TID_W-1:0];
            wr.data.nxt = rd.nxt;
            wr.data.ph  = rrts_pkg::PH_CREATED;
            wr.data.blk = '0;
            state_next  = rrts_pkg::S_CREATE2;
          end
          rrts_pkg::ACT_SCHED: begin
            wr.en       = 1'b1;
            wr.addr     = cur_tid;
            wr.data     = rd;
            wr.data.ph  = rrts_pkg::PH_READY;
            rd_addr     = rd.nxt;
            state_next  = rrts_pkg::S_WALK;
          end
          rrts_pkg::ACT_WAIT: begin
            wr.en       = 1'b1;
            wr.addr     = cur_tid;
            wr.data     = rd;
            wr.data.blk = sem_code;
            state_next  = rrts_pkg::S_DONE;
          end
          rrts_pkg::ACT_SIGNAL: begin
            rd_addr    = rd.nxt;
            state_next = rrts_pkg::S_WALK;
          end
          default: state_next = rrts_pkg::S_DONE;
        endcase
      end
      rrts_pkg::S_CREATE2: begin
        wr.en       = 1'b1;
        wr.addr     = cur_tid;
        wr.data     = ent;
        wr.data.nxt = res_tid;
        state_next  = rrts_pkg::S_DONE;
      end
      rrts_pkg::S_WALK: begin
        if (match) begin
          wr.en   = 1'b1;
          wr.addr = walk_t;
          wr.data = rd;
          if (act == rrts_pkg::ACT_SCHED) begin
            wr.data.ph = rrts_pkg::PH_RUNNING;
          end else begin
            wr.data.blk = '0;
          end
          state_next = rrts_pkg::S_DONE;
        end else if (last_step) begin
          state_next = rrts_pkg::S_DONE;
        end else begin
          rd_addr = rd.nxt;
        end
      end
      rrts_pkg::S_DONE: begin
        if (out_load) begin
          state_next = rrts_pkg::S_IDLE;
        end
      end
      default: state_next = rrts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_tid      <= '0;
      next_free_id <= (rrts_pkg::TID_W + 1)'(1);
    end else begin
      if (state == rrts_pkg::S_RDCUR && act == rrts_pkg::ACT_CREATE) begin
        next_free_id <= next_free_id + 1'b1;
      end
      if (state == rrts_pkg::S_WALK && match && act == rrts_pkg::ACT_SCHED) begin
        cur_tid <= walk_t;
      end
    end
  end

  // Item payload and walk bookkeeping.
  always_ff @(posedge clk) begin
    case (state)
      rrts_pkg::S_IDLE: begin
        if (accept) begin
          act        <= act_in;
          sem        <= sem_in;
          res_tid    <= cur_tid;
          res_first  <= 1'b0;
          res_susp   <= (act_in == rrts_pkg::ACT_WAIT) && sem_ok && (cnt_new < 0);
          res_status <= (act_in == rrts_pkg::ACT_CREATE && ring_full) ?
                        rrts_pkg::STS_NO_SLOT : rrts_pkg::STS_OK;
          res_semv   <= sem_op ? cnt_new : '0;
        end
      end
      rrts_pkg::S_RDCUR: begin
        ent    <= rd;
        walk_t <= rd.nxt;
        cnt    <= '0;
        if (act == rrts_pkg::ACT_CREATE) begin
          res_tid <= next_free_id[rrts_pkg::TID_W-1:0];
        end
      end
      rrts_pkg::S_WALK: begin
        if (match) begin
          if (act == rrts_pkg::ACT_SCHED) begin
            res_tid <= walk_t;
            // The current task was just marked ready, so it never counts as a first run.
            res_first <= (rd.ph == rrts_pkg::PH_CREATED) && (walk_t != cur_tid);
          end
        end else if (last_step) begin
          res_status <= (act == rrts_pkg::ACT_SCHED) ? rrts_pkg::STS_NO_RUN :
                        rrts_pkg::STS_NO_WAITER;
        end else begin
          walk_t <= rd.nxt;
          cnt    <= cnt + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {res_semv, res_status, res_susp, res_first, res_tid};
    end
  end

  `RRTS_ASSERT_IMP(a_busy_after_accept, clk, rst, accept, ##1 (state != rrts_pkg::S_IDLE))
  `RRTS_ASSERT(a_cur_created, clk, rst, next_free_id > {1'b0, cur_tid})
  `RRTS_ASSERT(a_nfid_range, clk, rst,
               next_free_id <= (rrts_pkg::TID_W + 1)'(rrts_pkg::TASK_SLOTS))
  `RRTS_ASSERT_IMP(a_out_from_done, clk, rst, $rose(m_tvalid), $past(state) == rrts_pkg::S_DONE)

endmodule
